// ===== src/mdcr_pkg.sv =====
// Shared constants, register codes and widths for the mic DC-block, clip and RMS block.
// Used by the top level and its port checker; no dependencies.
`default_nettype none

package mdcr_pkg;

   localparam int FRAME_SAMPLES = 960;
   localparam int MAX_BLOCK     = 512;

   localparam int FP_W   = $clog2(FRAME_SAMPLES + 1);
   localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W  = 40;
   localparam int ROOT_W = SUM_W / 2;
   localparam int ITER_W = $clog2(SUM_W + 1);

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // floor(m/100) = (m * RECIP_K) >> RECIP_SHIFT, exact for m < 2^32
   localparam logic [31:0] RECIP_K     = 32'd1374389535;
   localparam int          RECIP_SHIFT = 37;
   localparam logic [31:0] POLE_NUM    = 32'd97;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   localparam logic [1:0] REG_GAIN      = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_ENABLE    = 2'd2;

   localparam logic [3:0]  GAIN_RESET      = 4'd2;
   localparam logic [14:0] THRESHOLD_RESET = 15'd24000;

endpackage

`default_nettype wire

// ===== src/mic_dc_block_clip_rms.sv =====
// Mic cleanup: DC-blocking high-pass, RMS level meter and soft-clipped stream shaper.
// Depends on mdcr_pkg; one shared 32x32 multiplier plus an iterative divide/root unit.
//
// Usage:
//   req_* stream: one beat per left-slot I2S word; req_tlast marks the last sample of an
//   RMS block. rsp_* stream: exactly one beat per input beat carrying the clean sample,
//   the stream sample, the block level, and flags; rsp_tlast marks the end of a stream
//   frame of FRAME_SAMPLES streamed samples.
//   csr_* port: APB-style, gain at 0x0, clip threshold at 0x4, stream enable at 0x8.
//   Writing the enable register restarts the frame position.
// Timing:
//   A sample runs through a sequencer that reuses one multiplier for the pole product,
//   the divide-by-100 reciprocal, the square and the gain, then clips. On a block
//   end a restoring divide (sum/count) and a digit-serial square root follow before
//   the beat is sent. req_tready is high only while waiting for a new beat.
//   The result sits in an output register, so a new beat is taken while it waits;
//   a stalled receiver holds the block in its final step until the register frees.
// Reset: synchronous; clears filter, energy and frame state and loads register defaults.
`default_nettype none

module mic_dc_block_clip_rms
   import mdcr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] slot_word
   input  wire logic                  req_tlast,   // block_last
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [15:0] clean_sample, [31:16] stream_sample,
                                                   // [47:32] rms_level
   output logic [RSP_USER_W-1:0]      rsp_tuser,   // [0] stream_valid, [1] level_valid
   output logic                       rsp_tlast,   // frame_last
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_AW-1:0]     csr_paddr,
   input  wire logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_P97, ST_PDIV, ST_FILT, ST_SQ, ST_GAIN, ST_CLIP, ST_DIV, ST_SQRT, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]        gain_ff, gain_in;
   logic [14:0]       thresh_ff, thresh_in;
   logic              enable_ff, enable_in;
   logic [FP_W-1:0]   fp_ff, fp_in;

   logic signed [15:0] x_ff, x_in;
   logic               last_ff, last_in;
   logic signed [15:0] prev_in_ff, prev_in_in;
   logic signed [23:0] prev_out_ff, prev_out_in;
   logic [SUM_W-1:0]   energy_ff, energy_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic signed [15:0] v_ff, v_in;
   logic signed [15:0] stream_ff, stream_in;
   logic               sv_ff, sv_in;
   logic               fl_ff, fl_in;
   logic               lvl_ff, lvl_in;

   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        mul_a, mul_b;

   logic [SUM_W-1:0]   div_ff, div_in;
   logic [CNT_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W+1:0]  rsq_ff, rsq_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic               rsp_last_ff, rsp_last_in;

   // datapath helpers
   logic               psign;
   logic [23:0]        pmag;
   logic [23:0]        quot;
   logic signed [24:0] qterm;
   logic signed [24:0] y_wide;
   logic signed [23:0] y;
   logic [16:0]        vmag;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic [CNT_W-1:0]   count_next;
   logic               blk_end;
   logic [19:0]        amag;
   logic [19:0]        clip_mag;
   logic [CNT_W:0]     div_sh;
   logic [ROOT_W+3:0]  sq_sh;
   logic [ROOT_W+3:0]  sq_trial;
   logic               csr_wr;
   logic [1:0]         csr_idx;

   assign psign    = prev_out_ff[23];
   assign pmag     = psign ? 24'(-prev_out_ff) : 24'(prev_out_ff);
   assign quot     = prod_ff[RECIP_SHIFT+23:RECIP_SHIFT];
   assign qterm    = psign ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   assign y_wide   = $signed({{9{x_ff[15]}}, x_ff}) - $signed({{9{prev_in_ff[15]}}, prev_in_ff})
                     + qterm;
   assign y        = y_wide[23:0];
   assign vmag     = v_ff[15] ? 17'(-$signed({v_ff[15], v_ff})) : {1'b0, v_ff};
   assign sum_wide = {1'b0, energy_ff} + {{(SUM_W-30){1'b0}}, prod_ff[30:0]};
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign count_next = count_ff + 1'b1;
   assign blk_end  = last_ff || (count_next >= CNT_W'(MAX_BLOCK));
   assign amag     = prod_ff[19:0];
   assign clip_mag = (amag > {5'd0, thresh_ff})
                     ? {5'd0, thresh_ff} + ((amag - {5'd0, thresh_ff}) >> 2) : amag;
   assign div_sh   = {rem_ff, div_ff[SUM_W-1]};
   assign sq_sh    = {rsq_ff, div_ff[SUM_W-1:SUM_W-2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx  = csr_paddr[3:2];

   assign prod_in  = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      thresh_in    = thresh_ff;
      enable_in    = enable_ff;
      fp_in        = fp_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      prev_in_in   = prev_in_ff;
      prev_out_in  = prev_out_ff;
      energy_in    = energy_ff;
      count_in     = count_ff;
      v_in         = v_ff;
      stream_in    = stream_ff;
      sv_in        = sv_ff;
      fl_in        = fl_ff;
      lvl_in       = lvl_ff;
      div_in       = div_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      rsq_in       = rsq_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata[31:16];
               last_in  = req_tlast;
               state_in = ST_P97;
            end
         end
         ST_P97: begin
            mul_a    = {8'd0, pmag};
            mul_b    = POLE_NUM;
            state_in = ST_PDIV;
         end
         ST_PDIV: begin
            mul_a    = {2'd0, prod_ff[29:0]};
            mul_b    = RECIP_K;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            prev_in_in  = x_ff;
            prev_out_in = y;
            if (y > 24'sd32767) begin
               v_in = 16'sh7FFF;
            end else if (y < -24'sd32768) begin
               v_in = 16'sh8000;
            end else begin
               v_in = y[15:0];
            end
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a    = {15'd0, vmag};
            mul_b    = {15'd0, vmag};
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mul_a = {15'd0, vmag};
            mul_b = {28'd0, gain_ff};
            if (blk_end) begin
               div_in    = sum_sat;
               den_in    = count_next;
               energy_in = '0;
               count_in  = '0;
               lvl_in    = 1'b1;
            end else begin
               energy_in = sum_sat;
               count_in  = count_next;
               lvl_in    = 1'b0;
            end
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            sv_in     = enable_ff;
            fl_in     = 1'b0;
            stream_in = '0;
            if (enable_ff) begin
               if (v_ff[15]) begin
                  stream_in = (clip_mag > 20'd32768) ? 16'sh8000 : 16'(-clip_mag);
               end else begin
                  stream_in = (clip_mag > 20'd32767) ? 16'sh7FFF : clip_mag[15:0];
               end
               if ((fp_ff + 1'b1) >= FP_W'(FRAME_SAMPLES)) begin
                  fl_in = 1'b1;
                  fp_in = '0;
               end else begin
                  fp_in = fp_ff + 1'b1;
               end
            end
            iter_in  = ITER_W'(SUM_W - 1);
            rem_in   = '0;
            state_in = lvl_ff ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (div_sh >= {1'b0, den_ff}) begin
               rem_in = CNT_W'(div_sh - {1'b0, den_ff});
               div_in = {div_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_sh[CNT_W-1:0];
               div_in = {div_ff[SUM_W-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               iter_in  = ITER_W'(ROOT_W - 1);
               rsq_in   = '0;
               root_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            div_in = {div_ff[SUM_W-3:0], 2'b00};
            if (sq_sh >= sq_trial) begin
               rsq_in  = (ROOT_W+2)'(sq_sh - sq_trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rsq_in  = sq_sh[ROOT_W+1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {lvl_ff ? root_ff[15:0] : 16'd0, stream_ff, v_ff};
               rsp_user_in  = {lvl_ff, sv_ff};
               rsp_last_in  = fl_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr) begin
         case (csr_idx)
            REG_GAIN:      gain_in   = csr_pwdata[3:0];
            REG_THRESHOLD: thresh_in = csr_pwdata[14:0];
            REG_ENABLE: begin
               enable_in = csr_pwdata[0];
               fp_in     = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         thresh_ff    <= THRESHOLD_RESET;
         enable_ff    <= 1'b0;
         fp_ff        <= '0;
         prev_in_ff   <= '0;
         prev_out_ff  <= '0;
         energy_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         thresh_ff    <= thresh_in;
         enable_ff    <= enable_in;
         fp_ff        <= fp_in;
         prev_in_ff   <= prev_in_in;
         prev_out_ff  <= prev_out_in;
         energy_ff    <= energy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      last_ff     <= last_in;
      v_ff        <= v_in;
      stream_ff   <= stream_in;
      sv_ff       <= sv_in;
      fl_ff       <= fl_in;
      lvl_ff      <= lvl_in;
      prod_ff     <= prod_in;
      div_ff      <= div_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      rsq_ff      <= rsq_in;
      root_ff     <= root_in;
      iter_ff     <= iter_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      case (csr_idx)
         REG_GAIN:      csr_prdata = {28'd0, gain_ff};
         REG_THRESHOLD: csr_prdata = {17'd0, thresh_ff};
         REG_ENABLE:    csr_prdata = {31'd0, enable_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

// ===== src/mdcr_checker.sv =====
// Port-level checks for mic_dc_block_clip_rms, attached by the bind below.
// Depends on mdcr_pkg for bus widths.
`default_nettype none

module mdcr_checker
   import mdcr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser,
   input wire logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while a sample is in work");

   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[47:32] == 16'd0)
      else $error("rms level nonzero without level flag");

   a_stream_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:16] == 16'd0 && !rsp_tlast)
      else $error("stream data or frame end with streaming off");

endmodule

bind mic_dc_block_clip_rms mdcr_checker u_mdcr_checker (.*);

`default_nettype wire
